/* hdl/lennard_jones_force_accumulator_macros.svh */
// Assertion macros shared by the force accumulator RTL.
`ifndef LENNARD_JONES_FORCE_ACCUMULATOR_MACROS_SVH
`define LENNARD_JONES_FORCE_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during rst.
`define LJFA_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("ljfa: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define LJFA_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("ljfa: next-cycle check failed");

`else

`define LJFA_ASSERT_IMP(label, lhs, rhs)
`define LJFA_ASSERT_NXT(label, lhs, rhs)

`endif

`endif

/* hdl/ljfa_pkg.sv */
// Shared types and constants for the force accumulator.
package ljfa_pkg;

  // Operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    ALU_MULQ,    // a*b >> FRAC_BITS, saturated
    ALU_MULK,    // a*b, saturated to 64 bits
    ALU_MULDIV,  // floor(a*b/c), saturated
    ALU_SQ2,     // a*a + b*b, 128 bits
    ALU_SQRT     // floor(sqrt(a*a + b*b))
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // Configuration register indexes
  localparam logic [2:0] REG_ATTR_STR  = 3'd0;
  localparam logic [2:0] REG_REP_STR   = 3'd1;
  localparam logic [2:0] REG_GRAV_STR  = 3'd2;
  localparam logic [2:0] REG_GRAV_MODE = 3'd3;
  localparam logic [2:0] REG_MAX_FORCE = 3'd4;

  // Gravity direction codes
  localparam logic [1:0] GRAV_DOWN = 2'b01;
  localparam logic [1:0] GRAV_UP   = 2'b11;

  localparam logic [63:0] MAXS = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

/* hdl/ljfa_alu.sv */
// Shared multi-cycle unit: 32x32 partial-product multiplier, restoring divider and root.
module ljfa_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ljfa_pkg::alu_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [63:0]       c,
  output ljfa_pkg::alu_rsp_t rsp,
  output logic [63:0]       res,
  output logic [127:0]      acc
);

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_POST, U_DIV, U_SQRT} ustate_t;

  ustate_t            state;
  ljfa_pkg::alu_op_t  op_r;
  logic [63:0]        opa;
  logic [63:0]        opb;
  logic [63:0]        opc;
  logic [2:0]         step;
  logic [5:0]         cnt;
  logic [65:0]        rem;
  logic [63:0]        quo;
  logic               done;

  logic               sq;
  logic [63:0]        x_word;
  logic [63:0]        y_word;
  logic [31:0]        xh;
  logic [31:0]        yh;
  logic [63:0]        pp;
  logic [1:0]         sh_sel;
  logic [127:0]       pp_sh;
  logic [2:0]         last_step;
  logic [64:0]        rsh;
  logic               dge;
  logic [64:0]        dsub;
  logic [67:0]        remsh;
  logic [67:0]        trial;
  logic               sge;
  logic [67:0]        ssub;

  // Partial product selection: squares walk a then b
  always_comb begin
    sq        = (op_r == ljfa_pkg::ALU_SQ2) || (op_r == ljfa_pkg::ALU_SQRT);
    x_word    = (sq && step[2]) ? opb : opa;
    y_word    = sq ? x_word : opb;
    xh        = step[0] ? x_word[63:32] : x_word[31:0];
    yh        = step[1] ? y_word[63:32] : y_word[31:0];
    pp        = 64'(xh) * 64'(yh);
    sh_sel    = 2'(step[0]) + 2'(step[1]);
    pp_sh     = 128'(pp) << {sh_sel, 5'b0};
    last_step = sq ? 3'd7 : 3'd3;
  end

  // Restoring divide step
  always_comb begin
    rsh  = {rem[63:0], quo[63]};
    dge  = rsh >= {1'b0, opc};
    dsub = rsh - {1'b0, opc};
  end

  // Digit-by-digit root step
  always_comb begin
    remsh = {rem, acc[127:126]};
    trial = {2'b00, quo, 2'b01};
    sge   = remsh >= trial;
    ssub  = remsh - trial;
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (req.start) begin
            op_r  <= req.op;
            opa   <= a;
            opb   <= b;
            opc   <= c;
            acc   <= '0;
            step  <= '0;
            state <= U_MUL;
          end
        end
        U_MUL: begin
          acc  <= acc + pp_sh;
          step <= step + 3'd1;
          if (step == last_step) begin
            state <= U_POST;
          end
        end
        U_POST: begin
          unique case (op_r)
            ljfa_pkg::ALU_MULQ: begin
              res   <= ((acc >> (64 + FRAC_BITS)) != '0) ? '1 : acc[FRAC_BITS +: 64];
              done  <= 1'b1;
              state <= U_IDLE;
            end
            ljfa_pkg::ALU_MULK: begin
              res   <= (acc[127:64] != '0) ? '1 : acc[63:0];
              done  <= 1'b1;
              state <= U_IDLE;
            end
            ljfa_pkg::ALU_MULDIV: begin
              if (acc[127:64] >= opc) begin
                res   <= '1;
                done  <= 1'b1;
                state <= U_IDLE;
              end else begin
                rem   <= {2'b00, acc[127:64]};
                quo   <= acc[63:0];
                cnt   <= 6'd63;
                state <= U_DIV;
              end
            end
            ljfa_pkg::ALU_SQ2: begin
              done  <= 1'b1;
              state <= U_IDLE;
            end
            ljfa_pkg::ALU_SQRT: begin
              rem   <= '0;
              quo   <= '0;
              cnt   <= 6'd63;
              state <= U_SQRT;
            end
            default: begin
              done  <= 1'b1;
              state <= U_IDLE;
            end
          endcase
        end
        U_DIV: begin
          rem <= {2'b00, dge ? dsub[63:0] : rsh[63:0]};
          quo <= {quo[62:0], dge};
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            res   <= {quo[62:0], dge};
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        U_SQRT: begin
          rem <= sge ? ssub[65:0] : remsh[65:0];
          quo <= {quo[62:0], sge};
          acc <= acc << 2;
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            res   <= {quo[62:0], sge};
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign rsp = '{busy: (state != U_IDLE), done: done};

endmodule

/* hdl/lennard_jones_force_accumulator.sv */
// Lennard-Jones force accumulator: sequencer, accumulator and configuration registers.
//
// Each request carries a target and at most one neighbour; the block sums the pair forces
// in Q32.32 and, on the request marked last_pair, adds gravity, applies the magnitude limit
// and offers one result. Multiplies, divides and roots run on one shared unit (32x32
// multiply, divide and root), so a neighbour takes one root, nine multiply-divides and ten
// products, eight of them scaled. A request with no neighbour or a zero separation skips
// the pair arithmetic; last_pair adds the gravity and limit steps, and a rescaling when the
// limit applies. in_ready is high only between requests; a finished result waits in the
// output register while the next request is taken. No clearing pass follows reset.
// Configuration writes are always taken.
`include "lennard_jones_force_accumulator_macros.svh"

module lennard_jones_force_accumulator #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic [31:0]        target_mass,
  input  logic [31:0]        well_depth,
  input  logic [31:0]        target_radius,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic [31:0]        other_radius,
  input  logic               other_valid,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] force_x,
  output logic signed [63:0] force_y,
  output logic               was_clamped,
  output logic               zero_distance_seen
);

  localparam int          QSH   = 32 - FRAC_BITS;
  localparam logic [63:0] QLIM  = ljfa_pkg::MAXS >> QSH;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] K_ATT = 64'd24;
  localparam logic [63:0] K_REP = 64'd48;
  localparam logic [63:0] K_GRV = 64'd10;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ROOT, S_Q, S_Q2, S_Q4, S_Q6, S_Q12,
    S_EA, S_A1, S_A2, S_ER, S_R1, S_R2,
    S_CA1, S_CA2, S_CR1, S_CR2, S_ACC,
    S_G1, S_G2, S_GADD, S_LIM, S_SQF, S_SQL, S_M, S_NX, S_NY, S_EMIT
  } state_t;

  // Q(32-F).F value to saturated Q32.32
  function automatic logic [63:0] to_q32(input logic [63:0] v);
    logic [63:0] r;
    if (v > QLIM) begin
      r = ljfa_pkg::MAXS;
    end else begin
      r = v << QSH;
    end
    return r;
  endfunction

  // Signed add saturating at +-(2^63-1)
  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic signed [64:0] s;
    logic signed [64:0] hi;
    logic [63:0]        r;
    s  = $signed({x[63], x}) + $signed({y[63], y});
    hi = $signed({1'b0, ljfa_pkg::MAXS});
    if (s > hi) begin
      r = ljfa_pkg::MAXS;
    end else if (s < -hi) begin
      r = -ljfa_pkg::MAXS;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Configuration registers
  logic [31:0] attr_str;
  logic [31:0] rep_str;
  logic [31:0] grav_str;
  logic [1:0]  grav_mode;
  logic [31:0] max_force;

  // Request fields
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        adx;
  logic [32:0]        ady;
  logic [32:0]        rad_sum;
  logic [31:0]        mass;
  logic [31:0]        eps;
  logic               ov;
  logic               lp;

  // Working registers
  state_t       state;
  logic         issued;
  logic         axis;
  logic [63:0]  r;
  logic [63:0]  q;
  logic [63:0]  q2;
  logic [63:0]  q6;
  logic [63:0]  q12;
  logic [63:0]  t;
  logic [63:0]  attr;
  logic [63:0]  rep;
  logic [63:0]  ca;
  logic [63:0]  lim;
  logic [127:0] sumsq;
  logic [63:0]  sum_x;
  logic [63:0]  sum_y;
  logic         zero_flag;
  logic         clamped;

  ljfa_pkg::alu_req_t alu_req;
  ljfa_pkg::alu_rsp_t alu_rsp;
  logic [63:0]        alu_a;
  logic [63:0]        alu_b;
  logic [63:0]        alu_c;
  logic [63:0]        alu_res;
  logic [127:0]       alu_acc;
  logic               op_state;

  logic signed [32:0] dx_in;
  logic signed [32:0] dy_in;
  logic [63:0]        ad_cur;
  logic               d_neg;
  logic [63:0]        diff;
  logic [63:0]        contrib;

  assign dx_in = 33'(other_x) - 33'(target_x);
  assign dy_in = 33'(other_y) - 33'(target_y);

  assign ad_cur  = axis ? 64'(ady) : 64'(adx);
  assign d_neg   = axis ? dy[32] : dx[32];
  assign diff    = ca - t;
  assign contrib = d_neg ? -diff : diff;

  // Operand selection for the shared unit
  always_comb begin
    op_state    = 1'b1;
    alu_req.op  = ljfa_pkg::ALU_MULQ;
    alu_a       = '0;
    alu_b       = '0;
    alu_c       = '0;
    unique case (state)
      S_ROOT: begin
        alu_req.op = ljfa_pkg::ALU_SQRT;
        alu_a      = 64'(adx);
        alu_b      = 64'(ady);
      end
      S_Q: begin
        alu_req.op = ljfa_pkg::ALU_MULDIV;
        alu_a      = 64'(rad_sum);
        alu_b      = ONE_Q;
        alu_c      = r;
      end
      S_Q2:  begin alu_a = q;   alu_b = q;   end
      S_Q4:  begin alu_a = q2;  alu_b = q2;  end
      S_Q6:  begin alu_a = q;   alu_b = q2;  end
      S_Q12: begin alu_a = q6;  alu_b = q6;  end
      S_EA:  begin alu_a = 64'(eps); alu_b = 64'(attr_str); end
      S_A1:  begin alu_a = t;   alu_b = q6;  end
      S_A2: begin
        alu_req.op = ljfa_pkg::ALU_MULK;
        alu_a      = t;
        alu_b      = K_ATT;
      end
      S_ER:  begin alu_a = 64'(eps); alu_b = 64'(rep_str); end
      S_R1:  begin alu_a = t;   alu_b = q12; end
      S_R2: begin
        alu_req.op = ljfa_pkg::ALU_MULK;
        alu_a      = t;
        alu_b      = K_REP;
      end
      S_CA1, S_CR1: begin
        alu_req.op = ljfa_pkg::ALU_MULDIV;
        alu_a      = (state == S_CA1) ? attr : rep;
        alu_b      = ad_cur;
        alu_c      = r;
      end
      S_CA2, S_CR2: begin
        alu_req.op = ljfa_pkg::ALU_MULDIV;
        alu_a      = t;
        alu_b      = ONE_Q;
        alu_c      = r;
      end
      S_G1:  begin alu_a = 64'(mass); alu_b = 64'(grav_str); end
      S_G2: begin
        alu_req.op = ljfa_pkg::ALU_MULK;
        alu_a      = t;
        alu_b      = K_GRV;
      end
      S_LIM: begin alu_a = 64'(max_force); alu_b = 64'(mass); end
      S_SQF, S_M: begin
        alu_req.op = (state == S_M) ? ljfa_pkg::ALU_SQRT : ljfa_pkg::ALU_SQ2;
        alu_a      = mag(sum_x);
        alu_b      = mag(sum_y);
      end
      S_SQL: begin
        alu_req.op = ljfa_pkg::ALU_SQ2;
        alu_a      = lim;
      end
      S_NX, S_NY: begin
        alu_req.op = ljfa_pkg::ALU_MULDIV;
        alu_a      = (state == S_NX) ? mag(sum_x) : mag(sum_y);
        alu_b      = lim;
        alu_c      = r;
      end
      default: op_state = 1'b0;
    endcase
    alu_req.start = op_state && !issued;
  end

  ljfa_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .rsp (alu_rsp),
    .res (alu_res),
    .acc (alu_acc)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attr_str  <= 32'h0001_0000;
      rep_str   <= 32'h0001_0000;
      grav_str  <= '0;
      grav_mode <= '0;
      max_force <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ljfa_pkg::REG_ATTR_STR:  attr_str  <= cfg_data;
        ljfa_pkg::REG_REP_STR:   rep_str   <= cfg_data;
        ljfa_pkg::REG_GRAV_STR:  grav_str  <= cfg_data;
        ljfa_pkg::REG_GRAV_MODE: grav_mode <= cfg_data[1:0];
        ljfa_pkg::REG_MAX_FORCE: max_force <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main sequencer, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      axis      <= 1'b0;
      sum_x     <= '0;
      sum_y     <= '0;
      zero_flag <= 1'b0;
      clamped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A new result in S_EMIT takes over the output register itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      if (alu_req.start) begin
        issued <= 1'b1;
      end
      if (alu_rsp.done) begin
        issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dx      <= dx_in;
            dy      <= dy_in;
            adx     <= dx_in[32] ? -dx_in : dx_in;
            ady     <= dy_in[32] ? -dy_in : dy_in;
            rad_sum <= 33'(target_radius) + 33'(other_radius);
            mass    <= target_mass;
            eps     <= well_depth;
            ov      <= other_valid;
            lp      <= last_pair;
            state   <= S_DISP;
          end
        end
        S_DISP: begin
          if (ov && (dx != '0 || dy != '0)) begin
            axis  <= 1'b0;
            state <= S_ROOT;
          end else begin
            if (ov) begin
              zero_flag <= 1'b1;
            end
            state <= lp ? S_G1 : S_IDLE;
          end
        end
        S_ACC: begin
          if (axis) begin
            sum_y <= sat_add(sum_y, contrib);
            axis  <= 1'b0;
            state <= lp ? S_G1 : S_IDLE;
          end else begin
            sum_x <= sat_add(sum_x, contrib);
            axis  <= 1'b1;
            state <= S_CA1;
          end
        end
        S_GADD: begin
          if (grav_mode == ljfa_pkg::GRAV_DOWN) begin
            sum_y <= sat_add(sum_y, t);
          end else if (grav_mode == ljfa_pkg::GRAV_UP) begin
            sum_y <= sat_add(sum_y, -t);
          end
          state <= S_LIM;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            force_x            <= sum_x;
            force_y            <= sum_y;
            was_clamped        <= clamped;
            zero_distance_seen <= zero_flag;
            out_valid          <= 1'b1;
            sum_x              <= '0;
            sum_y              <= '0;
            zero_flag          <= 1'b0;
            clamped            <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: begin
          // Unit steps: take the result and move on
          if (alu_rsp.done) begin
            unique case (state)
              S_ROOT: begin r    <= alu_res; state <= S_Q;   end
              S_Q:    begin q    <= alu_res; state <= S_Q2;  end
              S_Q2:   begin q2   <= alu_res; state <= S_Q4;  end
              S_Q4:   begin q    <= alu_res; state <= S_Q6;  end
              S_Q6:   begin q6   <= alu_res; state <= S_Q12; end
              S_Q12:  begin q12  <= alu_res; state <= S_EA;  end
              S_EA:   begin t    <= alu_res; state <= S_A1;  end
              S_A1:   begin t    <= alu_res; state <= S_A2;  end
              S_A2:   begin attr <= alu_res; state <= S_ER;  end
              S_ER:   begin t    <= alu_res; state <= S_R1;  end
              S_R1:   begin t    <= alu_res; state <= S_R2;  end
              S_R2:   begin rep  <= alu_res; state <= S_CA1; end
              S_CA1:  begin t    <= alu_res; state <= S_CA2; end
              S_CA2:  begin ca   <= to_q32(alu_res); state <= S_CR1; end
              S_CR1:  begin t    <= alu_res; state <= S_CR2; end
              S_CR2:  begin t    <= to_q32(alu_res); state <= S_ACC; end
              S_G1:   begin t    <= alu_res; state <= S_G2;  end
              S_G2:   begin t    <= to_q32(alu_res); state <= S_GADD; end
              S_LIM:  begin lim  <= to_q32(alu_res); state <= S_SQF; end
              S_SQF:  begin sumsq <= alu_acc; state <= S_SQL; end
              S_SQL: begin
                if (sumsq >= alu_acc) begin
                  clamped <= 1'b1;
                  state   <= S_M;
                end else begin
                  state <= S_EMIT;
                end
              end
              S_M: begin
                if (alu_res == '0) begin
                  sum_x <= '0;
                  sum_y <= '0;
                  state <= S_EMIT;
                end else begin
                  r     <= alu_res;
                  state <= S_NX;
                end
              end
              S_NX: begin
                sum_x <= sum_x[63] ? -alu_res : alu_res;
                state <= S_NY;
              end
              S_NY: begin
                sum_y <= sum_y[63] ? -alu_res : alu_res;
                state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  `LJFA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LJFA_ASSERT_IMP(a_start_when_free, alu_req.start, !alu_rsp.busy)
  `LJFA_ASSERT_IMP(a_done_was_requested, alu_rsp.done, issued)

endmodule
